// ===== src/stereo_biquad_cascade_eq_core_macros.svh =====
// Assertion macros for the stereo biquad cascade equalizer core.
`ifndef STEREO_BIQUAD_CASCADE_EQ_CORE_MACROS_SVH
`define STEREO_BIQUAD_CASCADE_EQ_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SBQ_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");
`define SBQ_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");
`else
`define SBQ_ASSERT_IMPL(label, clk, rst, prop)
`define SBQ_ASSERT_NORST(label, clk, prop)
`endif
`endif

// ===== src/sbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants of the stereo biquad cascade equalizer.
// ----------------------------------------------------------------------------
package sbq_pkg;

  localparam int STATE_FRAC = 16;
  localparam int COEF_SLOTS = 5;

  // Configuration register indexes
  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_PREAMP = 2'd1;
  localparam logic [1:0] REG_LEFT_SECTIONS = 2'd2;
  localparam logic [1:0] REG_RIGHT_SECTIONS = 2'd3;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH = 25;

  // Command codes
  localparam logic CMD_PROCESS = 1'b0;
  localparam logic CMD_COEF = 1'b1;

  // Coefficient slots
  localparam logic [2:0] SLOT_B0 = 3'd0;
  localparam logic [2:0] SLOT_B1 = 3'd1;
  localparam logic [2:0] SLOT_B2 = 3'd2;
  localparam logic [2:0] SLOT_A1 = 3'd3;
  localparam logic [2:0] SLOT_A2 = 3'd4;

  typedef struct packed {
    logic               command;
    logic signed [31:0] left_sample;
    logic signed [31:0] right_sample;
    logic               coef_channel;
    logic [3:0]         coef_section;
    logic [2:0]         coef_slot;
    logic signed [31:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] left_out;
    logic signed [31:0] right_out;
  } out_item_t;

  // Datapath operation selected by the controller each cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_PREAMP,   // product of sample and gain
    OP_PRE_SAT,  // round, saturate, load v
    OP_RD,       // coefficient/delay reads in flight
    OP_M_B0,     // multiply b0*v
    OP_Y,        // form y
    OP_M_B1,     // multiply b1*v
    OP_M_A1,     // multiply a1*y
    OP_M_B2,     // multiply b2*v
    OP_M_A2,     // multiply a2*y
    OP_WB,       // write delays, advance v
    OP_FINAL,    // clamp and store channel result
    OP_PASS,     // load pass-through result
    OP_COEF_WR   // write coefficient and clear delays
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   chan;
    logic [5:0] section;
  } dp_cmd_t;

endpackage

// ===== src/sbq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/sbq_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_datapath
// Coefficient and delay stores, one shared multiplier and the biquad arithmetic.
// ----------------------------------------------------------------------------
module sbq_datapath import sbq_pkg::*; #(
  parameter int MAX_SECTIONS = 16,
  parameter int SAMPLE_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 26
) (
  input  logic      clk,
  input  logic      rst,
  input  dp_cmd_t   cmd,
  input  in_item_t  item,
  input  logic [24:0] preamp_gain,
  output out_item_t result
);

  localparam int SEC_W = $clog2(2 * MAX_SECTIONS);
  localparam int COEF_DEPTH = 2 * MAX_SECTIONS * COEF_SLOTS;
  localparam int COEF_AW = $clog2(COEF_DEPTH);
  localparam int PROD_SHIFT = COEF_FRAC_BITS - STATE_FRAC;
  localparam logic signed [63:0] SMAX = 64'sd2 ** (SAMPLE_WIDTH - 1) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;
  localparam logic signed [63:0] I32MAX = 64'sh7FFF_FFFF;
  localparam logic signed [63:0] I32MIN = -64'sh8000_0000;
  localparam logic signed [63:0] S48MAX = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] S48MIN = -64'sh8000_0000_0000;

  function automatic logic signed [63:0] clamp64(logic signed [63:0] x,
                                                 logic signed [63:0] lo,
                                                 logic signed [63:0] hi);
    logic signed [63:0] r;
    if (x < lo) r = lo;
    else if (x > hi) r = hi;
    else r = x;
    return r;
  endfunction

  // Section address: channel * MAX_SECTIONS + section
  logic [SEC_W-1:0] sec_addr;
  assign sec_addr = SEC_W'(32'(cmd.chan) * MAX_SECTIONS + 32'(cmd.section));

  // Coefficient walk: read one slot ahead of the multiply that uses it
  logic [2:0] rd_slot;
  always_comb begin
    unique case (cmd.op)
      OP_RD:   rd_slot = SLOT_B0;
      OP_Y:    rd_slot = SLOT_B1;
      OP_M_B1: rd_slot = SLOT_A1;
      OP_M_A1: rd_slot = SLOT_B2;
      OP_M_B2: rd_slot = SLOT_A2;
      default: rd_slot = SLOT_B0;
    endcase
  end

  // Valid bits for delay pairs (coef table valid per entry)
  logic [COEF_DEPTH-1:0] coef_valid;
  logic [2*MAX_SECTIONS-1:0] dly_valid;

  logic coef_we;
  logic [COEF_AW-1:0] coef_waddr, coef_raddr;
  logic [31:0] coef_rdata;
  logic [COEF_AW-1:0] coef_raddr_q;
  logic write_ok;

  assign write_ok = (item.coef_slot <= SLOT_A2) &&
                    (32'(item.coef_section) < MAX_SECTIONS);
  assign coef_we = (cmd.op == OP_COEF_WR) && write_ok;
  assign coef_waddr = COEF_AW'((32'(item.coef_channel) * MAX_SECTIONS +
                      32'(item.coef_section)) * COEF_SLOTS + 32'(item.coef_slot));
  assign coef_raddr = COEF_AW'(32'(sec_addr) * COEF_SLOTS + 32'(rd_slot));

  sbq_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk(clk), .we(coef_we), .waddr(coef_waddr), .wdata(item.coef_value),
    .raddr(coef_raddr), .rdata(coef_rdata)
  );

  // Delay state is small: registers, read at one address
  logic signed [47:0] d1 [2*MAX_SECTIONS];
  logic signed [47:0] d2 [2*MAX_SECTIONS];
  logic [SEC_W-1:0] wsec;
  assign wsec = SEC_W'(32'(item.coef_channel) * MAX_SECTIONS + 32'(item.coef_section));

  logic signed [31:0] coef;
  assign coef = coef_valid[coef_raddr_q] ? $signed(coef_rdata) : 32'sd0;

  // Working registers
  logic signed [31:0] v, y;
  logic signed [63:0] prod;
  logic signed [63:0] acc_d1, acc_d2;
  logic signed [63:0] mul_a, mul_b;
  logic signed [63:0] prod_sh;
  logic signed [63:0] dfirst, dsecond;
  logic signed [63:0] pre_rnd, yv;

  assign dfirst = dly_valid[sec_addr] ? 64'(d1[sec_addr]) : 64'sd0;
  assign dsecond = dly_valid[sec_addr] ? 64'(d2[sec_addr]) : 64'sd0;
  assign prod_sh = prod >>> PROD_SHIFT;
  assign pre_rnd = (prod + 64'sd8388608) >>> 24;
  assign yv = (acc_d1 + 64'sd32768) >>> STATE_FRAC;

  // Multiplier operand selection
  always_comb begin
    mul_a = 64'(coef);
    mul_b = 64'(v);
    unique case (cmd.op)
      OP_PREAMP: begin
        mul_a = clamp64(64'(cmd.chan ? item.right_sample : item.left_sample),
                        SMIN, SMAX);
        mul_b = $signed({39'd0, preamp_gain});
      end
      OP_M_A1, OP_M_A2: mul_b = 64'(y);
      default: ;
    endcase
  end

  // Shared signed 33 x 33 multiply and the section arithmetic
  always_ff @(posedge clk) begin
    coef_raddr_q <= coef_raddr;
    prod <= 64'($signed(mul_a[32:0])) * 64'($signed(mul_b[32:0]));
    unique case (cmd.op)
      OP_PRE_SAT: v <= 32'(clamp64(pre_rnd, I32MIN, I32MAX));
      OP_M_B0: ;
      OP_Y: acc_d1 <= prod_sh + dfirst;
      OP_M_B1: y <= 32'(clamp64(yv, I32MIN, I32MAX));
      OP_M_A1: acc_d2 <= prod_sh + dsecond;
      OP_M_B2: acc_d2 <= acc_d2 - prod_sh;
      OP_M_A2: acc_d1 <= prod_sh;
      OP_WB: begin
        acc_d1 <= acc_d1 - prod_sh;
        v <= y;
      end
      OP_FINAL: begin
        if (cmd.chan) result.right_out <= 32'(clamp64(64'(v), SMIN, SMAX));
        else result.left_out <= 32'(clamp64(64'(v), SMIN, SMAX));
      end
      OP_PASS: begin
        result.left_out <= item.left_sample;
        result.right_out <= item.right_sample;
      end
      default: ;
    endcase
  end

  // Delay writeback after both differences settle
  logic wb2;
  always_ff @(posedge clk) begin
    if (rst) begin
      wb2 <= 1'b0;
      coef_valid <= '0;
      dly_valid <= '0;
    end else begin
      wb2 <= (cmd.op == OP_WB);
      if (coef_we) begin
        coef_valid[coef_waddr] <= 1'b1;
        dly_valid[wsec] <= 1'b0;
      end
      if (wb2) begin
        dly_valid[sec_addr] <= 1'b1;
      end
    end
    if (wb2) begin
      d1[sec_addr] <= 48'(clamp64(acc_d2, S48MIN, S48MAX));
      d2[sec_addr] <= 48'(clamp64(acc_d1, S48MIN, S48MAX));
    end
  end

endmodule

// ===== src/sbq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbq_ctrl
// Sequencer that walks the sections of each channel through the datapath.
// ----------------------------------------------------------------------------
module sbq_ctrl import sbq_pkg::*; #(
  parameter int MAX_SECTIONS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     command,
  input  logic     enable,
  input  logic [4:0] left_sections,
  input  logic [4:0] right_sections,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     load,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_PSAT, S_RD, S_B0, S_Y, S_B1, S_A1, S_B2, S_A2, S_WB,
    S_WB2, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic chan;
  logic [5:0] sec;
  logic [5:0] count;
  logic [5:0] lim_l, lim_r;

  assign lim_l = (32'(left_sections) > MAX_SECTIONS) ? 6'(MAX_SECTIONS) : 6'(left_sections);
  assign lim_r = (32'(right_sections) > MAX_SECTIONS) ? 6'(MAX_SECTIONS) : 6'(right_sections);

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign load = in_valid && !in_stall;

  // Command to datapath
  always_comb begin
    cmd.chan = chan;
    cmd.section = sec;
    unique case (state)
      S_PRE:  cmd.op = OP_PREAMP;
      S_PSAT: cmd.op = OP_PRE_SAT;
      S_RD:   cmd.op = OP_RD;
      S_B0:   cmd.op = OP_M_B0;
      S_Y:    cmd.op = OP_Y;
      S_B1:   cmd.op = OP_M_B1;
      S_A1:   cmd.op = OP_M_A1;
      S_B2:   cmd.op = OP_M_B2;
      S_A2:   cmd.op = OP_M_A2;
      S_WB:   cmd.op = OP_WB;
      S_FIN:  cmd.op = OP_FINAL;
      default: cmd.op = OP_NONE;
    endcase
    if (state == S_IDLE && load) begin
      cmd.op = (command == CMD_COEF) ? OP_COEF_WR : (enable ? OP_NONE : OP_PASS);
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      chan <= 1'b0;
      sec <= '0;
      count <= '0;
    end else begin
      // Raise the result flag when a result is ready, drop it after its transfer
      if ((state == S_IDLE && load && command == CMD_PROCESS && !enable) ||
          state == S_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (load && command == CMD_PROCESS && enable) begin
          chan <= 1'b0;
          sec <= '0;
          count <= lim_l;
          state <= S_PRE;
        end
        S_PRE:  state <= S_PSAT;
        S_PSAT: state <= (count == 6'd0) ? S_FIN : S_RD;
        S_RD:   state <= S_B0;
        S_B0:   state <= S_Y;
        S_Y:    state <= S_B1;
        S_B1:   state <= S_A1;
        S_A1:   state <= S_B2;
        S_B2:   state <= S_A2;
        S_A2:   state <= S_WB;
        S_WB:   state <= S_WB2;
        S_WB2: begin
          if (sec + 6'd1 == count) begin
            state <= S_FIN;
          end else begin
            sec <= sec + 6'd1;
            state <= S_RD;
          end
        end
        S_FIN: begin
          if (!chan) begin
            chan <= 1'b1;
            sec <= '0;
            count <= lim_r;
            state <= S_PRE;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/stereo_biquad_cascade_eq_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo biquad cascade equalizer core
// Preamp and per-channel transposed direct form II biquad cascade.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_item) carries either a stereo frame
//   (command process) or a coefficient write (command coef). A coefficient
//   write updates one table entry, clears that section's delay pair and
//   yields no result. A frame yields one result on out_valid/out_stall/out_item.
//   A frame walks the preamp and each section of the left, then the right
//   channel through the single shared multiplier and coefficient RAM read
//   port, then the output register; no new item is taken meanwhile.
//   Disabled frames go straight to the output register; coefficient writes
//   are done when accepted. Reset clears the control and valid bits; the
//   coefficient table and delay state read as zero until written. The user
//   must write configuration (enable, preamp gain, section counts) through
//   cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
//   While the result is stalled it is held and no new item is taken.
// ----------------------------------------------------------------------------
`include "stereo_biquad_cascade_eq_core_macros.svh"
module stereo_biquad_cascade_eq_core import sbq_pkg::*; #(
  parameter int MAX_SECTIONS = 16,
  parameter int SAMPLE_WIDTH = 32,
  parameter int COEF_FRAC_BITS = 26
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_item_t in_item,
  output logic out_valid,
  input  logic out_stall,
  output out_item_t out_item,
  input  logic cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_data
);

  logic enable;
  logic [24:0] preamp_gain;
  logic [4:0] left_sections, right_sections;
  logic load;
  dp_cmd_t cmd;
  in_item_t item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
      preamp_gain <= 25'd16777216;
      left_sections <= '0;
      right_sections <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: enable <= cfg_data[0];
        REG_PREAMP: preamp_gain <= cfg_data[24:0];
        REG_LEFT_SECTIONS: left_sections <= cfg_data[4:0];
        REG_RIGHT_SECTIONS: right_sections <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item for the duration of its work
  always_ff @(posedge clk) begin
    if (load) item <= in_item;
  end

  in_item_t dp_item;
  assign dp_item = load ? in_item : item;

  sbq_ctrl #(.MAX_SECTIONS(MAX_SECTIONS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(in_item.command), .enable(enable),
    .left_sections(left_sections), .right_sections(right_sections),
    .out_valid(out_valid), .out_stall(out_stall), .load(load), .cmd(cmd)
  );

  sbq_datapath #(
    .MAX_SECTIONS(MAX_SECTIONS), .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .item(dp_item),
    .preamp_gain(preamp_gain), .result(out_item)
  );

  `SBQ_ASSERT_IMPL(a_no_load_while_out, clk, rst, (out_valid && out_stall) |-> !load)
  `SBQ_ASSERT_IMPL(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid)
  `SBQ_ASSERT_IMPL(a_busy_stalls, clk, rst, (cmd.op == OP_RD) |-> in_stall)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo equalizer core testbench
// Sends stereo frames and coefficient writes through the valid/stall input
// channel under several register settings, predicts each frame's filtered
// or passed-through samples, and checks every result in order while both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import sbq_pkg::*;

  localparam int NSEC = 16;
  localparam int PSHIFT = 10;
  localparam int IN_W = $bits(in_item_t);
  localparam logic signed [47:0] D48_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] D48_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -64'sd2147483648;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_item;
  logic out_valid;
  logic out_stall;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [CFG_DATA_WIDTH-1:0] cfg_data;

  stereo_biquad_cascade_eq_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state
  logic        eq_on;
  logic [24:0] gain;
  logic [4:0]  nsec_l, nsec_r;
  logic signed [31:0] coefs [0:2*NSEC*5-1];
  logic signed [47:0] dly1 [0:2*NSEC-1];
  logic signed [47:0] dly2 [0:2*NSEC-1];

  in_item_t  pending_items[$];
  out_item_t expected_frames[$];
  int errors = 0;
  int frames_seen = 0;
  int coef_writes = 0;
  bit cfg_busy = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic longint sat(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // Filter one channel sample through its cascade, updating delay state.
  function automatic logic signed [31:0] filter_channel(logic signed [31:0] x, int ch,
                                                        logic [4:0] cnt);
    longint v, acc, y, d1, d2, b0, b1, b2, a1, a2;
    int n, s, k;
    n = cnt > NSEC ? NSEC : cnt;
    v = (longint'(x) * longint'({1'b0, gain}) + (64'sd1 <<< 23)) >>> 24;
    v = sat(v, I32_MIN, I32_MAX);
    for (int i = 0; i < n; i++) begin
      s = ch * NSEC + i;
      k = s * 5;
      b0 = coefs[k]; b1 = coefs[k+1]; b2 = coefs[k+2];
      a1 = coefs[k+3]; a2 = coefs[k+4];
      acc = ((b0 * v) >>> PSHIFT) + longint'(dly1[s]);
      y = sat((acc + 32768) >>> 16, I32_MIN, I32_MAX);
      d1 = ((b1 * v) >>> PSHIFT) - ((a1 * y) >>> PSHIFT) + longint'(dly2[s]);
      d2 = ((b2 * v) >>> PSHIFT) - ((a2 * y) >>> PSHIFT);
      dly1[s] = 48'(sat(d1, longint'(D48_MIN), longint'(D48_MAX)));
      dly2[s] = 48'(sat(d2, longint'(D48_MIN), longint'(D48_MAX)));
      v = y;
    end
    return 32'(v);
  endfunction

  // Apply one accepted transfer to the predictor.
  task automatic predict_transfer(in_item_t it);
    out_item_t r;
    int s;
    if (it.command == CMD_COEF) begin
      if (it.coef_slot <= SLOT_A2) begin
        s = it.coef_channel * NSEC + it.coef_section;
        coefs[s*5 + it.coef_slot] = it.coef_value;
        dly1[s] = '0;
        dly2[s] = '0;
      end
      coef_writes++;
    end else begin
      if (!eq_on) begin
        r.left_out = it.left_sample;
        r.right_out = it.right_sample;
      end else begin
        r.left_out = filter_channel(it.left_sample, 0, nsec_l);
        r.right_out = filter_channel(it.right_sample, 1, nsec_r);
      end
      expected_frames.push_back(r);
    end
  endtask

  // Driver: present queued items, hold until the transfer happens.
  int in_gap = 0;
  bit in_taken = 0;
  always @(negedge clk) begin
    if (rst || cfg_busy) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // hold
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      in_gap <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Random output stall.
  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) < 3) ||
                      ($urandom_range(0, 99) == 0);
  end

  // Monitor: predict on input transfer, check on output transfer.
  always @(posedge clk) begin
    out_item_t e;
    in_taken = !rst && in_valid && !in_stall;
    if (in_taken) predict_transfer(in_item);
    if (!rst && out_valid && !out_stall) begin
      frames_seen++;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %h", out_item);
      end else begin
        e = expected_frames.pop_front();
        if (e.left_out !== out_item.left_out || e.right_out !== out_item.right_out) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: frame %0d exp L=%0d R=%0d got L=%0d R=%0d", frames_seen,
                     e.left_out, e.right_out, out_item.left_out, out_item.right_out);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [24:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENABLE: eq_on = val[0];
      REG_PREAMP: gain = val;
      REG_LEFT_SECTIONS: nsec_l = val[4:0];
      default: nsec_r = val[4:0];
    endcase
  endtask

  function automatic in_item_t frame(logic signed [31:0] l, logic signed [31:0] r);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.command = CMD_PROCESS;
    it.left_sample = l;
    it.right_sample = r;
    return it;
  endfunction

  function automatic in_item_t coef(logic ch, logic [3:0] sec, logic [2:0] slot,
                                    logic signed [31:0] val);
    in_item_t it;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom}));
    it.command = CMD_COEF;
    it.coef_channel = ch;
    it.coef_section = sec;
    it.coef_slot = slot;
    it.coef_value = val;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $urandom;
      default: return $signed($urandom) >>> $urandom_range(4, 16);
    endcase
  endfunction

  // Small, mostly stable coefficients with an occasional wild one.
  function automatic logic signed [31:0] rand_coef(logic [2:0] slot);
    if ($urandom_range(0, 15) == 0) return $urandom;
    if (slot == SLOT_B0) return 32'sd67108864 + ($signed($urandom) >>> 7);
    return $signed($urandom) >>> $urandom_range(8, 12);
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0);
    while (expected_frames.size() != 0 || in_valid) @(posedge clk);
    repeat (320) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int nl;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        nl = $urandom_range(0, 19);
        pending_items.push_back(coef(1'($urandom), 4'($urandom),
          nl == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
          rand_coef(3'($urandom_range(0, 4)))));
      end else begin
        pending_items.push_back(frame(rand_sample(), rand_sample()));
      end
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = '0;
    eq_on = 0; gain = 25'd16777216; nsec_l = 0; nsec_r = 0;
    for (int i = 0; i < 2*NSEC*5; i++) coefs[i] = '0;
    for (int i = 0; i < 2*NSEC; i++) begin dly1[i] = '0; dly2[i] = '0; end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: pass-through extremes, then coefficient loads and cascades
    pending_items.push_back(frame(32'sh7FFF_FFFF, 32'sh8000_0000));
    pending_items.push_back(frame(32'sd0, -32'sd1));
    for (int c = 0; c < 2; c++)
      for (int s = 0; s < NSEC; s++)
        pending_items.push_back(coef(1'(c), 4'(s), SLOT_B0, 32'sd67108864));
    pending_items.push_back(coef(1'b0, 4'd0, SLOT_B1, 32'sh7FFF_FFFF));
    pending_items.push_back(coef(1'b1, 4'd0, SLOT_A1, 32'sh8000_0000));
    pending_items.push_back(coef(1'b0, 4'd1, 3'd7, 32'sd5));
    pending_items.push_back(coef(1'b0, 4'd15, SLOT_A2, -32'sd1000));
    pending_items.push_back(coef(1'b1, 4'd15, SLOT_B2, 32'sd33554432));
    drain();

    cfg_busy = 1;
    write_reg(REG_ENABLE, 25'd1);
    write_reg(REG_PREAMP, 25'h1FF_FFFF);
    write_reg(REG_LEFT_SECTIONS, 25'd31);
    write_reg(REG_RIGHT_SECTIONS, 25'd16);
    cfg_busy = 0;
    pending_items.push_back(frame(32'sh7FFF_FFFF, 32'sh8000_0000));
    pending_items.push_back(frame(32'sh8000_0000, 32'sh7FFF_FFFF));
    pending_items.push_back(frame(32'sd12345, -32'sd12345));
    drain();

    // Random phases across settings
    for (int ph = 0; ph < 8; ph++) begin
      cfg_busy = 1;
      write_reg(REG_ENABLE, ph == 7 ? 25'd0 : 25'd1);
      write_reg(REG_PREAMP, ph == 0 ? 25'd0 : ph == 1 ? 25'd16777216 :
                ph == 2 ? 25'h1FF_FFFF : 25'($urandom_range(0, 33554431)));
      write_reg(REG_LEFT_SECTIONS, ph == 3 ? 25'd0 : 25'($urandom_range(0, 31)));
      write_reg(REG_RIGHT_SECTIONS, ph == 4 ? 25'd16 : 25'($urandom_range(0, 5)));
      cfg_busy = 0;
      random_phase(190);
    end

    $display("Covered %0d results and %0d coefficient writes over eight settings.",
             frames_seen, coef_writes);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: simulation limit reached");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
